// ===== design/two_set_store_with_set_algebra_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-set store
// Checks are clocked on clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TWO_SET_STORE_WITH_SET_ALGEBRA_ASSERT_SVH
`define TWO_SET_STORE_WITH_SET_ALGEBRA_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("two_set_store: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("two_set_store: next-cycle check failed");

`endif

// ===== design/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-set store package
// Sizes, operation and status codes, and the memory request type.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STAT_W   = 2;

  localparam logic [FUNC_W-1:0] F_CLEAR   = 3'd0;
  localparam logic [FUNC_W-1:0] F_INS_A   = 3'd1;
  localparam logic [FUNC_W-1:0] F_INS_B   = 3'd2;
  localparam logic [FUNC_W-1:0] F_QUERY   = 3'd3;
  localparam logic [FUNC_W-1:0] F_COMPARE = 3'd4;
  localparam logic [FUNC_W-1:0] F_UNION   = 3'd5;
  localparam logic [FUNC_W-1:0] F_INTER   = 3'd6;
  localparam logic [FUNC_W-1:0] F_DIFF    = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
  } ram_req_t;

endpackage

// ===== design/tss_ram.sv =====
// ----------------------------------------------------------------------------
// Set element memory
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
module tss_ram (
  input  logic                      clk,
  input  tss_pkg::ram_req_t         req,
  output logic [tss_pkg::DATA_W-1:0] rdata
);

  logic [tss_pkg::DATA_W-1:0] mem [tss_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

// ===== design/two_set_store_with_set_algebra.sv =====
// ----------------------------------------------------------------------------
// Two-set store with set algebra
// Clear goes straight to its single output word; insert, query and compare first scan both
// memories over max(|A|,|B|) entries, one entry per cycle, then update and put out one word.
// Runs step past each skipped entry, read then put out each element word, and step from A to B.
// One operation is in flight at a time; the next word is taken once the block is back in idle.
// Reset empties both sets at once; the element memories are not cleared.
// ----------------------------------------------------------------------------
module two_set_store_with_set_algebra (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // element[31:0], in_a, in_b, a_subset_b,
                                 // a_strict_subset_b, sets_equal, status[1:0], pad
  output logic        m_tuser,   // element_valid
  output logic        m_tlast    // last
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_UPD    = 3'd2;
  localparam logic [2:0] S_SINGLE = 3'd3;
  localparam logic [2:0] S_RUN_RD = 3'd4;
  localparam logic [2:0] S_RUN_WR = 3'd5;

  localparam logic [tss_pkg::CNT_W-1:0] FULL_CNT = tss_pkg::CNT_W'(tss_pkg::CAPACITY);
  localparam logic [tss_pkg::CNT_W-1:0] ONE_CNT  = tss_pkg::CNT_W'(1);

  logic [2:0]                       state;
  logic [tss_pkg::FUNC_W-1:0]       func_r;
  logic [tss_pkg::DATA_W-1:0]       value_r;
  logic [tss_pkg::CNT_W-1:0]        cnt_a;
  logic [tss_pkg::CNT_W-1:0]        cnt_b;
  logic [tss_pkg::CAPACITY-1:0]     a_in_b;
  logic [tss_pkg::CAPACITY-1:0]     b_in_a;
  logic [tss_pkg::CNT_W-1:0]        scan_idx;
  logic [tss_pkg::CNT_W-1:0]        pend_idx;
  logic                             pend_valid;
  logic                             hit_a;
  logic                             hit_b;
  logic [tss_pkg::IDX_W-1:0]        hit_a_idx;
  logic [tss_pkg::IDX_W-1:0]        hit_b_idx;
  logic                             in_a_r;
  logic                             in_b_r;
  logic [tss_pkg::STAT_W-1:0]       status_r;
  logic                             run_set;
  logic [tss_pkg::CNT_W-1:0]        run_idx;

  logic [tss_pkg::DATA_W-1:0]       out_elem;
  logic                             out_evalid;
  logic                             out_last;
  logic                             out_in_a;
  logic                             out_in_b;
  logic                             out_sub;
  logic                             out_strict;
  logic                             out_eq;
  logic [tss_pkg::STAT_W-1:0]       out_status;

  tss_pkg::ram_req_t                req_a;
  tss_pkg::ram_req_t                req_b;
  logic [tss_pkg::DATA_W-1:0]       rdata_a;
  logic [tss_pkg::DATA_W-1:0]       rdata_b;

  logic [tss_pkg::CNT_W-1:0]        scan_len;
  logic                             scan_more;
  logic                             ins_a_ok;
  logic                             ins_b_ok;
  logic                             out_free;
  logic                             out_load;
  logic [tss_pkg::CAPACITY-1:0]     valid_a;
  logic [tss_pkg::CAPACITY-1:0]     valid_b;
  logic [tss_pkg::CAPACITY-1:0]     emit_a;
  logic [tss_pkg::CAPACITY-1:0]     emit_b;
  logic [tss_pkg::CAPACITY-1:0]     above;
  logic                             sub;
  logic                             a_done;
  logic                             cur_bit;
  logic                             run_read;
  logic                             run_last;
  logic [tss_pkg::DATA_W-1:0]       run_data;

  tss_ram u_ram_a (.clk(clk), .req(req_a), .rdata(rdata_a));
  tss_ram u_ram_b (.clk(clk), .req(req_b), .rdata(rdata_b));

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && ((state == S_SINGLE) || (state == S_RUN_WR));
  assign scan_len  = (cnt_a > cnt_b) ? cnt_a : cnt_b;
  assign scan_more = (scan_idx < scan_len);
  assign ins_a_ok  = (func_r == tss_pkg::F_INS_A) && !hit_a && (cnt_a != FULL_CNT);
  assign ins_b_ok  = (func_r == tss_pkg::F_INS_B) && !hit_b && (cnt_b != FULL_CNT);

  assign valid_a = ~({tss_pkg::CAPACITY{1'b1}} << cnt_a);
  assign valid_b = ~({tss_pkg::CAPACITY{1'b1}} << cnt_b);
  assign sub     = &(a_in_b | ~valid_a);

  always_comb begin
    case (func_r)
      tss_pkg::F_UNION: emit_a = valid_a;
      tss_pkg::F_INTER: emit_a = valid_a & a_in_b;
      default:          emit_a = valid_a & ~a_in_b;
    endcase
  end

  assign emit_b   = (func_r == tss_pkg::F_UNION) ? (valid_b & ~b_in_a) : '0;
  assign above    = {tss_pkg::CAPACITY{1'b1}} << (run_idx + ONE_CNT);
  assign a_done   = !run_set && (run_idx >= cnt_a);
  assign cur_bit  = run_set ? emit_b[run_idx[tss_pkg::IDX_W-1:0]]
                            : emit_a[run_idx[tss_pkg::IDX_W-1:0]];
  assign run_read = !a_done && cur_bit;
  assign run_last = run_set ? ((emit_b & above) == '0)
                            : (((emit_a & above) == '0) && (emit_b == '0));
  assign run_data = run_set ? rdata_b : rdata_a;

  always_comb begin
    req_a = '0;
    req_b = '0;
    unique case (state)
      S_SCAN: begin
        req_a.rd_en   = scan_more;
        req_a.rd_addr = scan_idx[tss_pkg::IDX_W-1:0];
        req_b.rd_en   = scan_more;
        req_b.rd_addr = scan_idx[tss_pkg::IDX_W-1:0];
      end
      S_UPD: begin
        req_a.wr_en   = ins_a_ok;
        req_a.wr_addr = cnt_a[tss_pkg::IDX_W-1:0];
        req_a.wr_data = value_r;
        req_b.wr_en   = ins_b_ok;
        req_b.wr_addr = cnt_b[tss_pkg::IDX_W-1:0];
        req_b.wr_data = value_r;
      end
      S_RUN_RD: begin
        req_a.rd_en   = run_read && !run_set;
        req_a.rd_addr = run_idx[tss_pkg::IDX_W-1:0];
        req_b.rd_en   = run_read && run_set;
        req_b.rd_addr = run_idx[tss_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt_a      <= '0;
      cnt_b      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func_r     <= s_tuser;
            value_r    <= s_tdata;
            scan_idx   <= '0;
            pend_valid <= 1'b0;
            hit_a      <= 1'b0;
            hit_b      <= 1'b0;
            in_a_r     <= 1'b0;
            in_b_r     <= 1'b0;
            status_r   <= tss_pkg::ST_OK;
            if (s_tuser == tss_pkg::F_CLEAR) begin
              cnt_a <= '0;
              cnt_b <= '0;
              state <= S_SINGLE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend_valid <= scan_more;
          pend_idx   <= scan_idx;
          if (scan_more) begin
            scan_idx <= scan_idx + ONE_CNT;
          end
          if (pend_valid) begin
            if ((rdata_a == value_r) && (pend_idx < cnt_a)) begin
              hit_a     <= 1'b1;
              hit_a_idx <= pend_idx[tss_pkg::IDX_W-1:0];
            end
            if ((rdata_b == value_r) && (pend_idx < cnt_b)) begin
              hit_b     <= 1'b1;
              hit_b_idx <= pend_idx[tss_pkg::IDX_W-1:0];
            end
          end
          if (!scan_more && !pend_valid) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          in_a_r <= hit_a || ins_a_ok;
          in_b_r <= hit_b || ins_b_ok;
          if (func_r == tss_pkg::F_INS_A) begin
            status_r <= hit_a ? tss_pkg::ST_DUP
                      : ((cnt_a == FULL_CNT) ? tss_pkg::ST_FULL : tss_pkg::ST_OK);
          end else if (func_r == tss_pkg::F_INS_B) begin
            status_r <= hit_b ? tss_pkg::ST_DUP
                      : ((cnt_b == FULL_CNT) ? tss_pkg::ST_FULL : tss_pkg::ST_OK);
          end
          if (ins_a_ok) begin
            a_in_b[cnt_a[tss_pkg::IDX_W-1:0]] <= hit_b;
            if (hit_b) begin
              b_in_a[hit_b_idx] <= 1'b1;
            end
            cnt_a <= cnt_a + ONE_CNT;
          end
          if (ins_b_ok) begin
            b_in_a[cnt_b[tss_pkg::IDX_W-1:0]] <= hit_a;
            if (hit_a) begin
              a_in_b[hit_a_idx] <= 1'b1;
            end
            cnt_b <= cnt_b + ONE_CNT;
          end
          run_set <= 1'b0;
          run_idx <= '0;
          if ((func_r <= tss_pkg::F_COMPARE) || ((emit_a == '0) && (emit_b == '0))) begin
            state <= S_SINGLE;
          end else begin
            state <= S_RUN_RD;
          end
        end
        S_SINGLE: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_elem   <= '0;
            out_evalid <= 1'b0;
            out_last   <= 1'b1;
            out_in_a   <= in_a_r;
            out_in_b   <= in_b_r;
            out_sub    <= sub;
            out_strict <= sub && (cnt_a < cnt_b);
            out_eq     <= sub && (cnt_a == cnt_b);
            out_status <= status_r;
            state      <= S_IDLE;
          end
        end
        S_RUN_RD: begin
          if (a_done) begin
            run_set <= 1'b1;
            run_idx <= '0;
          end else if (cur_bit) begin
            state <= S_RUN_WR;
          end else begin
            run_idx <= run_idx + ONE_CNT;
          end
        end
        S_RUN_WR: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_elem   <= run_data;
            out_evalid <= 1'b1;
            out_last   <= run_last;
            out_in_a   <= in_a_r;
            out_in_b   <= in_b_r;
            out_sub    <= sub;
            out_strict <= sub && (cnt_a < cnt_b);
            out_eq     <= sub && (cnt_a == cnt_b);
            out_status <= tss_pkg::ST_OK;
            run_idx    <= run_idx + ONE_CNT;
            state      <= run_last ? S_IDLE : S_RUN_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {1'b0, out_status, out_eq, out_strict, out_sub,
                    out_in_b, out_in_a, out_elem};
  assign m_tuser = out_evalid;
  assign m_tlast = out_last;

`include "two_set_store_with_set_algebra_assert.svh"

  `TSS_ASSERT_SAME(a_cnt_in_range, 1'b1, (cnt_a <= FULL_CNT) && (cnt_b <= FULL_CNT))
  `TSS_ASSERT_NEXT(busy_after_accept, s_tvalid && s_tready, state != S_IDLE)
  `TSS_ASSERT_SAME(strict_excludes_equal, m_tvalid, !(out_strict && out_eq))
  `TSS_ASSERT_NEXT(run_word_is_element, (state == S_RUN_WR) && out_free,
                   m_tvalid && out_evalid)

endmodule

// ===== dv/set_algebra_checker.sv =====
// ----------------------------------------------------------------------------
// Set algebra result checker
// Watches both stream channels of the two-set store. It keeps its own copy
// of sets A and B, works out the words that each accepted operation should
// return, and compares every returned word with the oldest one still due.
// ----------------------------------------------------------------------------
module set_algebra_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [2:0]  s_tuser,   // func[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // element[31:0], in_a, in_b, a_subset_b,
                                 // a_strict_subset_b, sets_equal, status[1:0], pad
  input  logic        m_tuser,   // element_valid
  input  logic        m_tlast,   // last
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [tss_pkg::DATA_W-1:0] element;
    logic                       element_valid;
    logic                       last_flag;
    logic                       in_a;
    logic                       in_b;
    logic                       a_subset_b;
    logic                       a_strict_subset_b;
    logic                       sets_equal;
    logic [tss_pkg::STAT_W-1:0] status;
    logic                       pad;
  } set_word_t;

  logic [tss_pkg::DATA_W-1:0] set_a [tss_pkg::CAPACITY];
  logic [tss_pkg::DATA_W-1:0] set_b [tss_pkg::CAPACITY];
  int unsigned       count_a = 0;
  int unsigned       count_b = 0;
  set_word_t         due_words [$];
  int                mismatch_total = 0;

  assign failures = mismatch_total;

  function automatic bit in_set_a(input logic [tss_pkg::DATA_W-1:0] v);
    for (int i = 0; i < count_a; i++)
      if (set_a[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit in_set_b(input logic [tss_pkg::DATA_W-1:0] v);
    for (int i = 0; i < count_b; i++)
      if (set_b[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [tss_pkg::STAT_W-1:0] store_value(
      input bit to_b, input logic [tss_pkg::DATA_W-1:0] v);
    if (to_b ? in_set_b(v) : in_set_a(v)) return tss_pkg::ST_DUP;
    if ((to_b ? count_b : count_a) >= tss_pkg::CAPACITY) return tss_pkg::ST_FULL;
    if (to_b) begin
      set_b[count_b] = v;
      count_b++;
    end else begin
      set_a[count_a] = v;
      count_a++;
    end
    return tss_pkg::ST_OK;
  endfunction

  function automatic set_word_t make_word(input logic valid,
                                          input logic [tss_pkg::DATA_W-1:0] elem,
                                          input logic last_flag,
                                          input logic [tss_pkg::STAT_W-1:0] st,
                                          input logic [tss_pkg::DATA_W-1:0] v);
    set_word_t w;
    bit        a_covered;
    a_covered = 1'b1;
    for (int i = 0; i < count_a; i++)
      if (!in_set_b(set_a[i])) a_covered = 1'b0;
    w.element           = valid ? elem : '0;
    w.element_valid     = valid;
    w.last_flag         = last_flag;
    w.in_a              = in_set_a(v);
    w.in_b              = in_set_b(v);
    w.a_subset_b        = a_covered;
    w.a_strict_subset_b = a_covered && (count_a < count_b);
    w.sets_equal        = a_covered && (count_a == count_b);
    w.status            = st;
    w.pad               = 1'b0;
    return w;
  endfunction

  // Updates the sets and queues every word that the operation returns.
  task automatic apply_operation(input logic [tss_pkg::FUNC_W-1:0] op,
                                 input logic [tss_pkg::DATA_W-1:0] v);
    logic [tss_pkg::STAT_W-1:0] st;
    logic [tss_pkg::DATA_W-1:0] run [$];
    st = tss_pkg::ST_OK;
    case (op)
      tss_pkg::F_CLEAR: begin
        count_a = 0;
        count_b = 0;
      end
      tss_pkg::F_INS_A: st = store_value(1'b0, v);
      tss_pkg::F_INS_B: st = store_value(1'b1, v);
      default: ;
    endcase
    for (int i = 0; i < count_a; i++)
      if (op == tss_pkg::F_UNION || (op == tss_pkg::F_INTER && in_set_b(set_a[i])) ||
          (op == tss_pkg::F_DIFF && !in_set_b(set_a[i])))
        run.insert(run.size(), set_a[i]);
    if (op == tss_pkg::F_UNION)
      for (int i = 0; i < count_b; i++)
        if (!in_set_a(set_b[i])) run.insert(run.size(), set_b[i]);
    if (run.size() == 0)
      due_words.insert(due_words.size(), make_word(1'b0, '0, 1'b1, st, v));
    else
      for (int i = 0; i < run.size(); i++)
        due_words.insert(due_words.size(),
                         make_word(1'b1, run[i], i == run.size() - 1, tss_pkg::ST_OK, v));
  endtask

  function automatic bit field_ok(input string name, input logic [tss_pkg::DATA_W-1:0] want,
                                  input logic [tss_pkg::DATA_W-1:0] got);
    if (want === got) return 1'b1;
    $display("%0t: %s expected %h, got %h", $time, name, want, got);
    return 1'b0;
  endfunction

  function automatic bit flag_ok(input string name, input logic want, input logic got);
    if (want === got) return 1'b1;
    $display("%0t: %s expected %b, got %b", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    set_word_t got;
    set_word_t want;
    bit        ok;
    if (rst) begin
      count_a = 0;
      count_b = 0;
      due_words.delete();
    end else begin
      if (s_tvalid && s_tready) apply_operation(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tuser, m_tlast, m_tdata[32], m_tdata[33], m_tdata[34],
               m_tdata[35], m_tdata[36], m_tdata[38:37], m_tdata[39]};
        if (due_words.size() == 0) begin
          $display("%0t: expected no word, got element %h last %b", $time,
                   got.element, got.last_flag);
          mismatch_total++;
        end else begin
          want = due_words.pop_front();
          ok = field_ok("element", want.element, got.element) &
               flag_ok("element_valid", want.element_valid, got.element_valid) &
               flag_ok("last", want.last_flag, got.last_flag) &
               flag_ok("in_a", want.in_a, got.in_a) &
               flag_ok("in_b", want.in_b, got.in_b) &
               flag_ok("a_subset_b", want.a_subset_b, got.a_subset_b) &
               flag_ok("a_strict_subset_b", want.a_strict_subset_b,
                       got.a_strict_subset_b) &
               flag_ok("sets_equal", want.sets_equal, got.sets_equal) &
               field_ok("status", tss_pkg::DATA_W'(want.status),
                        tss_pkg::DATA_W'(got.status)) &
               flag_ok("pad", want.pad, got.pad);
          if (!ok) mismatch_total++;
        end
      end
    end
    pending = due_words.size();
  end

endmodule

// ===== dv/two_set_store_with_set_algebra_test.sv =====
// ----------------------------------------------------------------------------
// Two-set store testbench
// Drives operations into the two-set store with random gaps and stalls: a
// short directed sequence over empty sets, extreme values, duplicates and
// subset relations, then random episodes of well-formed insert sequences,
// filled sets and stray operations. The checker beside the block judges
// every returned word.
// ----------------------------------------------------------------------------
module two_set_store_with_set_algebra_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // value[31:0]
  logic [2:0]  s_tuser  = '0;   // func[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // element[31:0], in_a, in_b, a_subset_b,
                                // a_strict_subset_b, sets_equal, status[1:0], pad
  logic        m_tuser;         // element_valid
  logic        m_tlast;         // last
  int          failures;
  int          pending;
  int          words_sent = 0;
  int          stall_left = 0;
  bit          quiet      = 1'b0;

  always #1 clk = ~clk;

  two_set_store_with_set_algebra dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  set_algebra_checker u_sets (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .failures (failures),
    .pending  (pending)
  );

  // Mostly short gaps, now and then a long one, none during a quiet stretch.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_word(input logic [tss_pkg::FUNC_W-1:0] op,
                           input logic [tss_pkg::DATA_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= tss_pkg::FUNC_W'($urandom_range(0, 7));
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int                         episode;
    int                         na;
    int                         nb;
    int                         shape;
    logic [tss_pkg::DATA_W-1:0] base_a;
    logic [tss_pkg::DATA_W-1:0] base_b;
    logic [tss_pkg::DATA_W-1:0] pick;
    logic [tss_pkg::DATA_W-1:0] pool [10];
    logic [tss_pkg::DATA_W-1:0] a_vals [$];

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty sets, extreme values, a duplicate, then B growing past A.
    send_word(tss_pkg::F_COMPARE, 32'h0000_0000);
    send_word(tss_pkg::F_UNION,   32'h8000_0000);
    send_word(tss_pkg::F_INTER,   32'h7FFF_FFFF);
    send_word(tss_pkg::F_DIFF,    32'hFFFF_FFFF);
    send_word(tss_pkg::F_INS_A,   32'h8000_0000);
    send_word(tss_pkg::F_INS_A,   32'h7FFF_FFFF);
    send_word(tss_pkg::F_INS_A,   32'h0000_0000);
    send_word(tss_pkg::F_INS_A,   32'h7FFF_FFFF);
    send_word(tss_pkg::F_COMPARE, 32'h8000_0000);
    send_word(tss_pkg::F_INS_B,   32'hFFFF_FFFF);
    send_word(tss_pkg::F_INS_B,   32'h7FFF_FFFF);
    send_word(tss_pkg::F_INS_B,   32'h8000_0000);
    send_word(tss_pkg::F_QUERY,   32'hFFFF_FFFF);
    send_word(tss_pkg::F_QUERY,   $urandom);
    send_word(tss_pkg::F_UNION,   32'h0000_0000);
    send_word(tss_pkg::F_INTER,   32'h7FFF_FFFF);
    send_word(tss_pkg::F_DIFF,    32'h0000_0000);
    send_word(tss_pkg::F_INS_B,   32'h0000_0000);
    send_word(tss_pkg::F_COMPARE, 32'hFFFF_FFFF);
    send_word(tss_pkg::F_DIFF,    32'h8000_0000);
    send_word(tss_pkg::F_INS_A,   32'hFFFF_FFFF);
    send_word(tss_pkg::F_QUERY,   32'h0000_0000);
    send_word(tss_pkg::F_INTER,   32'h5555_5555);
    send_word(tss_pkg::F_CLEAR,   32'hAAAA_AAAA);
    send_word(tss_pkg::F_UNION,   32'h0000_0000);

    episode = 0;
    while (words_sent < 350) begin
      quiet = ($urandom_range(0, 5) == 0);
      if (episode == 2 || episode == 9) begin
        // A filled to capacity, B to within two of it or full; B overlapping A or apart.
        base_a = $urandom;
        base_b = ($urandom_range(0, 1) != 0) ? base_a + 32'd16 : base_a + 32'd1000;
        send_word(tss_pkg::F_CLEAR, $urandom);
        for (int i = 0; i < tss_pkg::CAPACITY + 2; i++) send_word(tss_pkg::F_INS_A, base_a + i);
        send_word(tss_pkg::F_INS_A, base_a);
        nb = $urandom_range(tss_pkg::CAPACITY - 2, tss_pkg::CAPACITY + 1);
        for (int i = 0; i < nb; i++) send_word(tss_pkg::F_INS_B, base_b + i);
        send_word(tss_pkg::F_QUERY, base_a + tss_pkg::CAPACITY);
        send_word(tss_pkg::F_COMPARE, base_b);
        send_word(tss_pkg::F_UNION, $urandom);
        send_word(tss_pkg::F_INTER, base_a + 20);
        send_word(tss_pkg::F_DIFF, $urandom);
      end else begin
        base_a = $urandom;
        for (int i = 0; i < 10; i++)
          pool[i] = ($urandom_range(0, 4) == 0) ? $urandom : base_a + $urandom_range(0, 15);
        if ($urandom_range(0, 3) != 0) send_word(tss_pkg::F_CLEAR, $urandom);
        a_vals.delete();
        na    = $urandom_range(0, 7);
        shape = $urandom_range(0, 3);
        for (int i = 0; i < na; i++) begin
          pick = pool[$urandom_range(0, 9)];
          a_vals.insert(a_vals.size(), pick);
          send_word(tss_pkg::F_INS_A, pick);
        end
        case (shape)
          0: begin
            nb = $urandom_range(0, 7);
            for (int i = 0; i < nb; i++)
              send_word(tss_pkg::F_INS_B, pool[$urandom_range(0, 9)]);
          end
          1: for (int i = a_vals.size() - 1; i >= 0; i--) send_word(tss_pkg::F_INS_B, a_vals[i]);
          2: begin
            foreach (a_vals[i]) send_word(tss_pkg::F_INS_B, a_vals[i]);
            nb = $urandom_range(1, 3);
            for (int i = 0; i < nb; i++)
              send_word(tss_pkg::F_INS_B, pool[$urandom_range(0, 9)]);
          end
          default:
            foreach (a_vals[i])
              if ($urandom_range(0, 1) != 0) send_word(tss_pkg::F_INS_B, a_vals[i]);
        endcase
        nb = $urandom_range(2, 6);
        for (int i = 0; i < nb; i++) begin
          if ($urandom_range(0, 6) == 0)
            send_word(tss_pkg::FUNC_W'($urandom_range(0, 7)), $urandom);
          pick = ($urandom_range(0, 1) != 0) ? pool[$urandom_range(0, 9)] : $urandom;
          send_word(tss_pkg::FUNC_W'($urandom_range(tss_pkg::F_QUERY, tss_pkg::F_DIFF)), pick);
        end
      end
      episode++;
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/tss_pkg.sv
design/tss_ram.sv
design/two_set_store_with_set_algebra.sv
dv/set_algebra_checker.sv
dv/two_set_store_with_set_algebra_test.sv
